>>> src/mbrd_pkg.sv
package mbrd_pkg;

    localparam int unsigned WORD_W = 31;
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned PROD_W = WORD_W + MUL_W;

    localparam logic [WORD_W-1:0] LEHMER_MOD = 31'h7fffffff;
    localparam logic [MUL_W-1:0]  LEHMER_MUL = 16'hbc8f;
    localparam logic [WORD_W-1:0] SPAN       = 31'h7ffffffe;
    localparam logic [WORD_W-1:0] MAX_LIMIT  = 31'h7ffffffd;
    localparam logic [WORD_W-1:0] COIN_LIMIT = 31'd1000000;
    localparam logic [WORD_W-1:0] COIN_DIVISOR = WORD_W'(SPAN / (COIN_LIMIT + 31'd1));

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_SEED = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_COIN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVD_WAIT,
        ST_MUL,
        ST_REDUCE,
        ST_QSTART,
        ST_QWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic seed_load;
        logic clear_value;
        logic div_start;
        logic div_sel_quot;
        logic latch_divisor;
        logic divisor_coin;
        logic mul;
        logic reduce;
        logic latch_q;
        logic out_write;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       limit_zero;
        logic       div_done;
        logic       q_over;
    } dp_stat_t;

endpackage

>>> src/mbrd_div.sv
module mbrd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mbrd_pkg::WORD_W-1:0]   dividend,
    input  logic [mbrd_pkg::WORD_W-1:0]   divisor,
    output logic                          done,
    output logic [mbrd_pkg::WORD_W-1:0]   quotient
);

    localparam int unsigned W = mbrd_pkg::WORD_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy_reg) |=> busy_reg && (cnt_reg == '0))
        else $error("divider did not begin its count");
`endif

endmodule

>>> src/mbrd_dpath.sv
module mbrd_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    in_opcode,
    input  logic [31:0]                   in_seed_value,
    input  logic [mbrd_pkg::WORD_W-1:0]   in_draw_limit,
    input  logic [19:0]                   in_threshold_ppm,
    input  mbrd_pkg::dp_cmd_t             cmd,
    output mbrd_pkg::dp_stat_t            stat,
    output logic [mbrd_pkg::WORD_W-1:0]   out_value,
    output logic                          out_hit
);

    localparam int unsigned W = mbrd_pkg::WORD_W;
    localparam int unsigned P = mbrd_pkg::PROD_W;

    logic [1:0]   op_reg;
    logic [31:0]  seed_reg;
    logic [W-1:0] limit_reg;
    logic [19:0]  thr_reg;
    logic [W-1:0] state_reg, state_next;
    logic [W-1:0] divisor_reg;
    logic [P-1:0] prod_reg;
    logic [W-1:0] value_reg;
    logic [W-1:0] out_value_reg;
    logic         out_hit_reg;

    logic [W-1:0] limit_sat;
    logic [W:0]   seed_sum;
    logic [W:0]   seed_red;
    logic [W:0]   prod_sum;
    logic [W:0]   prod_red;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic         div_done;
    logic [W-1:0] div_quo;

    // 2^31 is 1 modulo 2^31-1: fold the high part onto the low part
    always_comb begin
        limit_sat = (in_draw_limit > mbrd_pkg::MAX_LIMIT) ? mbrd_pkg::MAX_LIMIT
                                                          : in_draw_limit;
        seed_sum  = {1'b0, seed_reg[W-1:0]} + (W+1)'(seed_reg[31]);
        seed_red  = (seed_sum >= {1'b0, mbrd_pkg::LEHMER_MOD})
                  ? seed_sum - {1'b0, mbrd_pkg::LEHMER_MOD} : seed_sum;
        prod_sum  = {1'b0, prod_reg[W-1:0]} + (W+1)'(prod_reg[P-1:W]);
        prod_red  = (prod_sum >= {1'b0, mbrd_pkg::LEHMER_MOD})
                  ? prod_sum - {1'b0, mbrd_pkg::LEHMER_MOD} : prod_sum;

        state_next = state_reg;
        if (cmd.seed_load) begin
            state_next = (seed_red[W-1:0] == '0) ? W'(1) : seed_red[W-1:0];
        end else if (cmd.reduce) begin
            state_next = prod_red[W-1:0];
        end

        if (cmd.div_sel_quot) begin
            div_dividend = state_reg - W'(1);
            div_divisor  = divisor_reg;
        end else begin
            div_dividend = mbrd_pkg::SPAN;
            div_divisor  = limit_reg + W'(1);
        end
    end

    mbrd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W'(1);
        end else begin
            state_reg <= state_next;
        end
        if (cmd.load_item) begin
            op_reg    <= in_opcode;
            seed_reg  <= in_seed_value;
            thr_reg   <= in_threshold_ppm;
            limit_reg <= (in_opcode == mbrd_pkg::OP_COIN) ? mbrd_pkg::COIN_LIMIT
                                                          : limit_sat;
        end
        if (cmd.latch_divisor) begin
            divisor_reg <= div_quo;
        end else if (cmd.divisor_coin) begin
            divisor_reg <= mbrd_pkg::COIN_DIVISOR;
        end
        if (cmd.mul) begin
            prod_reg <= P'(state_reg) * P'(mbrd_pkg::LEHMER_MUL);
        end
        if (cmd.clear_value) begin
            value_reg <= '0;
        end else if (cmd.latch_q) begin
            value_reg <= div_quo;
        end
        if (cmd.out_write) begin
            out_value_reg <= value_reg;
            out_hit_reg   <= (op_reg == mbrd_pkg::OP_COIN)
                          && (value_reg <= W'(thr_reg));
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.limit_zero = (limit_reg == '0);
        stat.div_done   = div_done;
        stat.q_over     = (div_quo > limit_reg);
    end

    assign out_value = out_value_reg;
    assign out_hit   = out_hit_reg;

`ifndef SYNTHESIS
    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != '0) && (state_reg != mbrd_pkg::LEHMER_MOD))
        else $error("generator state left 1 .. 2^31-2");
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start && cmd.div_sel_quot) |-> (divisor_reg != '0))
        else $error("quotient division started with zero divisor");
    a_accept_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch_q |-> !stat.q_over && div_done)
        else $error("draw accepted above its limit");
`endif

endmodule

>>> src/mbrd_ctrl.sv
module mbrd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mbrd_pkg::dp_stat_t    stat,
    output mbrd_pkg::dp_cmd_t     cmd
);

    mbrd_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mbrd_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = mbrd_pkg::ST_DECODE;
            end
            mbrd_pkg::ST_DECODE: begin
                if (stat.op == mbrd_pkg::OP_DRAW && !stat.limit_zero) begin
                    state_next = mbrd_pkg::ST_DIVD_WAIT;
                end else if (stat.op == mbrd_pkg::OP_COIN) begin
                    state_next = mbrd_pkg::ST_MUL;
                end else begin
                    state_next = mbrd_pkg::ST_OUT;
                end
            end
            mbrd_pkg::ST_DIVD_WAIT: begin
                if (stat.div_done) state_next = mbrd_pkg::ST_MUL;
            end
            mbrd_pkg::ST_MUL:    state_next = mbrd_pkg::ST_REDUCE;
            mbrd_pkg::ST_REDUCE: state_next = mbrd_pkg::ST_QSTART;
            mbrd_pkg::ST_QSTART: state_next = mbrd_pkg::ST_QWAIT;
            mbrd_pkg::ST_QWAIT: begin
                // redraw on reject
                if (stat.div_done) begin
                    state_next = stat.q_over ? mbrd_pkg::ST_MUL : mbrd_pkg::ST_OUT;
                end
            end
            mbrd_pkg::ST_OUT: begin
                if (out_free) state_next = mbrd_pkg::ST_IDLE;
            end
            default: state_next = mbrd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            mbrd_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            mbrd_pkg::ST_DECODE: begin
                if (stat.op == mbrd_pkg::OP_SEED) begin
                    cmd.seed_load   = 1'b1;
                    cmd.clear_value = 1'b1;
                end else if (stat.op == mbrd_pkg::OP_DRAW && !stat.limit_zero) begin
                    cmd.div_start = 1'b1;
                end else if (stat.op == mbrd_pkg::OP_COIN) begin
                    cmd.divisor_coin = 1'b1;
                end else begin
                    cmd.clear_value = 1'b1;
                end
            end
            mbrd_pkg::ST_DIVD_WAIT: cmd.latch_divisor = stat.div_done;
            mbrd_pkg::ST_MUL:       cmd.mul = 1'b1;
            mbrd_pkg::ST_REDUCE:    cmd.reduce = 1'b1;
            mbrd_pkg::ST_QSTART: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_quot = 1'b1;
            end
            mbrd_pkg::ST_QWAIT: begin
                cmd.div_sel_quot = 1'b1;
                cmd.latch_q      = stat.div_done && !stat.q_over;
            end
            mbrd_pkg::ST_OUT: cmd.out_write = out_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_write) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mbrd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> (!out_valid_reg || m_tready))
        else $error("result overwrote a beat not yet taken");
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == mbrd_pkg::ST_DECODE))
        else $error("accepted beat not decoded");
    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == mbrd_pkg::ST_DIVD_WAIT
                           || state_reg == mbrd_pkg::ST_QWAIT))
        else $error("division finished outside a wait state");
    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |=> m_tvalid)
        else $error("result written but not presented");
`endif

endmodule

>>> src/minstd_bounded_random_draw.sv
// channel  | valid/ready          | tdata (low bit up)                       | tuser
// input    | s_tvalid / s_tready  | seed_value 32, draw_limit 31,            | opcode 2
//          |                      | threshold_ppm 20, pad 5                  |
// result   | m_tvalid / m_tready  | drawn_value 31, coin_hit 1               | -
//
// Seed, zero-limit draw and unused opcode: take, decode, output.
// Integer draw: take, decode and the divisor division, then attempts until one is accepted;
// coin draw skips the divisor division and uses a fixed divisor. Each attempt is the 31x16
// multiply and fold, then a quotient on the shared one-bit-per-cycle divider (31 steps).
// One item at a time; a new beat is taken once the previous result is in the
// output register, even if that beat is still waiting on m_tready.
// aresetn (synchronous) sets the generator state to 1 and empties the output.
module minstd_bounded_random_draw (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // seed_value, draw_limit, threshold_ppm, zero pad
    input  logic [1:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // drawn_value, coin_hit
);

    mbrd_pkg::dp_cmd_t  cmd;
    mbrd_pkg::dp_stat_t stat;
    logic [mbrd_pkg::WORD_W-1:0] out_value;
    logic                        out_hit;

    mbrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbrd_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_opcode        (s_tuser),
        .in_seed_value    (s_tdata[31:0]),
        .in_draw_limit    (s_tdata[62:32]),
        .in_threshold_ppm (s_tdata[82:63]),
        .cmd              (cmd),
        .stat             (stat),
        .out_value        (out_value),
        .out_hit          (out_hit)
    );

    assign m_tdata = {out_hit, out_value};

endmodule
